// ===== sv/rtu_pkg.sv =====
`timescale 1ns / 1ps

package rtu_pkg;

    localparam int MAX_FRAME  = 256;
    localparam int CNT_W      = $clog2(MAX_FRAME + 1);
    localparam int BYTE_W     = 8;
    localparam int CRC_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [BYTE_W-1:0] ADDR_BROADCAST = 8'hFF;
    localparam logic [BYTE_W-1:0] SLAVE_ID_RESET = 8'h01;
    localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY       = 16'hA001;

    // register index taken from the word-aligned part of paddr
    localparam logic REG_SLAVE_ID = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_ADDR  = 3'd1,
        ST_CRC   = 3'd2,
        ST_SHORT = 3'd3,
        ST_LONG  = 3'd4
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } rx_word_t;

    // reflected crc-16, one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== sv/rtu_rx_if.sv =====
`timescale 1ns / 1ps

interface rtu_rx_if;
    import rtu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== sv/rtu_res_if.sv =====
`timescale 1ns / 1ps

interface rtu_res_if;
    import rtu_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                broadcast;
    logic [CNT_W-1:0]    frame_length;

    modport source (output valid, output status, output broadcast, output frame_length,
                    input ready);
    modport sink   (input valid, input status, input broadcast, input frame_length,
                    output ready);
endinterface

// ===== sv/rtu_apb_regs.sv =====
`timescale 1ns / 1ps

module rtu_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtu_pkg::PADDR_W-1:0]     paddr,
    input  logic [rtu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rtu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [rtu_pkg::BYTE_W-1:0]      slave_id
);
    import rtu_pkg::*;

    logic              wr_en;
    logic              sel_slave_id;
    logic [BYTE_W-1:0] slave_id_reg;
    logic [BYTE_W-1:0] slave_id_next;

    assign pready       = 1'b1;
    assign sel_slave_id = (paddr[PADDR_W-1] == REG_SLAVE_ID);
    assign wr_en        = psel && penable && pwrite && pready;

    always_comb
    begin
        slave_id_next = slave_id_reg;
        if (wr_en && sel_slave_id)
            slave_id_next = pwdata[BYTE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_id_reg <= SLAVE_ID_RESET;
        else
            slave_id_reg <= slave_id_next;
    end

    always_comb
    begin
        prdata = '0;
        if (sel_slave_id)
            prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, slave_id_reg};
    end

    assign slave_id = slave_id_reg;
endmodule

// ===== sv/rtu_in_stage.sv =====
`timescale 1ns / 1ps

module rtu_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    rtu_rx_if.sink            rx,
    input  logic              advance,
    output logic              word_valid,
    output rtu_pkg::rx_word_t word
);
    import rtu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_word_t word_reg;
    logic     take;

    // stage frees up in the same cycle its word moves on
    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.data_byte <= rx.data_byte;
            word_reg.last_byte <= rx.last_byte;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;
endmodule

// ===== sv/rtu_frame_core.sv =====
`timescale 1ns / 1ps

module rtu_frame_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [rtu_pkg::BYTE_W-1:0] slave_id,
    input  logic                       word_valid,
    input  rtu_pkg::rx_word_t          word,
    output logic                       advance,
    rtu_res_if.source                  res
);
    import rtu_pkg::*;

    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;
    logic [BYTE_W-1:0] addr_reg;
    logic [BYTE_W-1:0] addr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           out_status_reg;
    logic              out_bcast_reg;
    logic [CNT_W-1:0]  out_len_reg;

    logic              out_free;
    logic              finish;
    logic [CRC_W-1:0]  crc_upd;
    logic [BYTE_W-1:0] addr_upd;
    logic [CNT_W-1:0]  count_upd;
    logic              ovf_upd;
    status_t           status_upd;

    assign out_free = !out_valid_reg || res.ready;
    // a closing byte needs the result register, other bytes never wait
    assign advance  = word_valid && (!word.last_byte || out_free);
    assign finish   = advance && word.last_byte;

    always_comb
    begin
        addr_upd  = (count_reg == '0) ? word.data_byte : addr_reg;
        count_upd = count_reg;
        crc_upd   = crc_reg;
        ovf_upd   = ovf_reg;
        if (count_reg < CNT_W'(MAX_FRAME))
        begin
            count_upd = count_reg + 1'b1;
            crc_upd   = crc_feed(crc_reg, word.data_byte);
        end
        else
        begin
            ovf_upd = 1'b1;
        end

        if (count_upd < CNT_W'(3))
            status_upd = ST_SHORT;
        else if (ovf_upd)
            status_upd = ST_LONG;
        else if (addr_upd != ADDR_BROADCAST && addr_upd != slave_id)
            status_upd = ST_ADDR;
        else if (crc_upd != '0)
            status_upd = ST_CRC;
        else
            status_upd = ST_OK;
    end

    always_comb
    begin
        crc_next   = crc_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (finish)
        begin
            crc_next   = CRC_INIT;
            addr_next  = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (advance)
        begin
            crc_next   = crc_upd;
            addr_next  = addr_upd;
            count_next = count_upd;
            ovf_next   = ovf_upd;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            addr_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_status_reg <= status_upd;
            out_bcast_reg  <= (addr_upd == ADDR_BROADCAST);
            out_len_reg    <= count_upd;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.broadcast    = out_bcast_reg;
    assign res.frame_length = out_len_reg;

`ifndef ASSERT_OFF
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(word_valid && word.last_byte))
        else $error("result appeared without a closing byte");

    a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (count_reg == '0 && crc_reg == CRC_INIT && !ovf_reg))
        else $error("frame state not cleared after result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAME))
        else $error("byte count past frame limit");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CNT_W'(MAX_FRAME))
        else $error("overflow set below frame limit");

    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_SHORT) |-> out_len_reg < CNT_W'(3))
        else $error("short status on a long frame");
`endif
endmodule

// ===== sv/rtu_frame_checker.sv =====
`timescale 1ns / 1ps

// channel   dir   handshake        word
// rx        in    valid / ready    data_byte[7:0], last_byte
// res       out   valid / ready    status[2:0], broadcast, frame_length[8:0]
// apb       in    psel / penable   register 0 at 0x0: slave_id[7:0], reset 1
//
// one byte per cycle sustained while no closing byte waits on a held result; a byte is
// held in the input register while the crc/length/address update is worked out from
// it, and a frame's status is written from there into the result register.
// async active-low reset clears the frame state and both valid flags, slave_id goes to 1.
// a waiting result holds only the closing byte of the next frame in the input
// register and rx stalls behind it; the bytes before it keep flowing while res is held.

module rtu_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtu_pkg::PADDR_W-1:0]     paddr,
    input  logic [rtu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rtu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    rtu_rx_if.sink                          rx,
    rtu_res_if.source                       res
);
    import rtu_pkg::*;

    logic [BYTE_W-1:0] slave_id;
    logic              word_valid;
    rx_word_t          word;
    logic              advance;

    rtu_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .slave_id (slave_id)
    );

    rtu_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    rtu_frame_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .slave_id   (slave_id),
        .word_valid (word_valid),
        .word       (word),
        .advance    (advance),
        .res        (res)
    );
endmodule
